// ===== sv/mpq_pkg.sv =====
// Package for the max priority queue: beat structs, stored entry layout,
// command and status codes. No dependencies.
package mpq_pkg;

    // Command codes of an input beat.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Status codes of a result beat.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Width of the occupancy field of a result beat.
    localparam int OCC_W = 5;

    // One stored entry: character over signed priority.
    typedef struct packed {
        logic [7:0]         ch;
        logic signed [15:0] prio;
    } entry_t;

    // Input beat.
    typedef struct packed {
        logic               command;
        logic [7:0]         item_char;
        logic signed [15:0] priority_req;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         out_char;
        logic signed [15:0] out_priority;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

endpackage

// ===== sv/mpq_store.sv =====
// Entry store of the max priority queue: one write port, one read port,
// registered read data. Depends on mpq_pkg for the entry layout.
module mpq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  mpq_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output mpq_pkg::entry_t rd_data
);

    mpq_pkg::entry_t mem_reg [DEPTH];
    mpq_pkg::entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mpq_ctrl.sv =====
// Sequencer of the max priority queue: insert, maximum scan and compaction
// over the entry store. Depends on mpq_pkg; drives mpq_store.
module mpq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mpq_pkg::req_t   req,
    output logic            busy,
    output logic            res_valid,
    output mpq_pkg::rsp_t   res,
    output logic            wr_en,
    output logic [AW-1:0]   wr_addr,
    output mpq_pkg::entry_t wr_data,
    output logic            rd_en,
    output logic [AW-1:0]   rd_addr,
    input  mpq_pkg::entry_t rd_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    mpq_pkg::entry_t best_reg, best_next;
    logic            first_reg, first_next;

    logic [CW-1:0]             count_m1;
    logic [AW-1:0]             last_idx;
    logic                      take;
    mpq_pkg::entry_t           cur_best;
    logic [AW-1:0]             cur_idx;
    logic [CW+mpq_pkg::OCC_W-1:0] count_wide;

    assign count_m1 = count_reg - 1'b1;
    assign last_idx = count_m1[AW-1:0];

    // Running maximum: the first word read is the newest entry; later ones
    // replace it only when strictly greater, so the newest of equals stays.
    assign take     = first_reg || (rd_data.prio > best_reg.prio);
    assign cur_best = take ? rd_data : best_reg;
    assign cur_idx  = take ? ptr_reg : best_idx_reg;

    assign busy = (state_reg != S_IDLE);

    // Next state and memory access.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        first_next    = first_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg - 1'b1;
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg;
        res_valid     = 1'b0;
        res.status    = mpq_pkg::ST_OK;
        res.out_char  = '0;
        res.out_priority = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.command == mpq_pkg::CMD_INSERT)
                    begin
                        res_valid = 1'b1;
                        if (count_reg == CW'(DEPTH))
                        begin
                            res.status = mpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = count_reg[AW-1:0];
                            wr_data.ch   = req.item_char;
                            wr_data.prio = req.priority_req;
                            count_next   = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_valid  = 1'b1;
                        res.status = mpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Start the scan at the newest entry.
                        rd_en      = 1'b1;
                        rd_addr    = last_idx;
                        ptr_next   = last_idx;
                        first_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                first_next    = 1'b0;
                best_next     = cur_best;
                best_idx_next = cur_idx;
                if (ptr_reg == '0)
                begin
                    if (cur_idx == last_idx)
                    begin
                        // Maximum is the newest entry: nothing to close up.
                        res_valid        = 1'b1;
                        res.out_char     = cur_best.ch;
                        res.out_priority = cur_best.prio;
                        count_next       = count_m1;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cur_idx + 1'b1;
                        ptr_next   = cur_idx + 1'b1;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - 1'b1;
                    ptr_next = ptr_reg - 1'b1;
                end
            end

            S_SHIFT:
            begin
                // Move the word read last cycle one slot toward the oldest end.
                wr_en = 1'b1;
                if (ptr_reg == last_idx)
                begin
                    res_valid        = 1'b1;
                    res.out_char     = best_reg.ch;
                    res.out_priority = best_reg.prio;
                    count_next       = count_m1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Occupancy after this command, masked to the field width.
        count_wide    = (CW + mpq_pkg::OCC_W)'(count_next);
        res.occupancy = count_wide[mpq_pkg::OCC_W-1:0];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Scan registers.
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        first_reg    <= first_next;
    end

endmodule

// ===== sv/max_priority_queue.sv =====
// Top level of the max priority queue: entry store, sequencer, result register.
// Depends on mpq_pkg, mpq_store and mpq_ctrl.
//
// A bounded priority queue of up to DEPTH (character, signed priority) entries.
// A command beat is taken at a clock edge with start high and busy low. Every
// command gives exactly one result beat, shown for one cycle with done high;
// the receiver cannot stall it. The result of an insert shows in the next
// cycle, with busy staying low. An extract of n held entries walks the store
// from newest to oldest, one read a cycle through the single read port, then
// closes the gap behind the removed entry one word a cycle; busy stays high
// until it is through, and the result is registered from its last step. On
// equal priorities the newest entry is removed.
module max_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mpq_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output mpq_pkg::rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    mpq_pkg::entry_t wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    mpq_pkg::entry_t rd_data;
    logic            res_valid;
    mpq_pkg::rsp_t   res;
    logic            done_reg;
    mpq_pkg::rsp_t   rsp_reg;

    mpq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mpq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/mpq_checker.sv =====
// Port-level checks of the max priority queue, bound to the top level.
// Depends on mpq_pkg and max_priority_queue.
module mpq_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input mpq_pkg::req_t req,
    input logic          busy,
    input logic          done,
    input mpq_pkg::rsp_t rsp
);

    // An accepted insert answers in the very next cycle.
    a_insert_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.command == mpq_pkg::CMD_INSERT) |=> done)
        else $error("insert beat not answered in the next cycle");

    // A result never shows while a command is still being worked on.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // An error result (empty or full) carries a zero entry.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != mpq_pkg::ST_OK) |->
            (rsp.out_char == '0 && rsp.out_priority == '0))
        else $error("error result carries an entry");

    // An extract on an empty queue leaves it empty.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == mpq_pkg::ST_EMPTY) |-> (rsp.occupancy == '0))
        else $error("empty status with nonzero occupancy");

endmodule

bind max_priority_queue mpq_port_checker u_mpq_checker (.*);
